// ===== hw/rtl/mrac_pkg.sv =====
// Package for the mixed-radix assignment counter: widths, command, status and
// register codes, payload structs and the cell interface structs.
// No dependencies.
`default_nettype none
package mrac_pkg;

  // Digit storage
  localparam int MAX_DIGITS  = 8;
  localparam int DIGIT_WIDTH = 8;
  localparam int RADIX_WIDTH = 8;
  localparam int CMP_WIDTH   = (DIGIT_WIDTH + 1 > RADIX_WIDTH) ? DIGIT_WIDTH + 1 : RADIX_WIDTH;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int VAL_W     = 8;
  localparam int IDX_W     = 64;
  localparam int STAT_W    = 2;
  localparam int RADICES_W = 64;
  localparam int NUM_W     = 4;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ONE   = 2'd0,
    CMD_SET_ALL   = 2'd1,
    CMD_UNSET_ALL = 2'd2,
    CMD_ADVANCE   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_NONE     = 2'd0,
    STAT_ADVANCED = 2'd1,
    STAT_WRAPPED  = 2'd2,
    STAT_STOPPED  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADICES    = 1'd0,
    CFG_NUM_DIGITS = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic              index_valid;
    logic [STAT_W-1:0] advance_status;
  } out_item_t;

  // Write controls broadcast to one cell
  typedef struct packed {
    logic                   wr;
    logic                   clr;
    logic [DIGIT_WIDTH-1:0] wdata;
  } cell_wr_t;

  // What a cell reports the cycle after the sweep token passed it
  typedef struct packed {
    logic                   vld;
    logic [DIGIT_WIDTH-1:0] value;
    logic                   known;
    logic [RADIX_WIDTH-1:0] radix;
    logic                   stop;
    logic                   adv;
  } cell_tap_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mixed_radix_assignment_counter.sv =====
// Top level of the mixed-radix assignment counter: config registers, the row
// of digit cells, the shared index multiply-accumulate and the result register.
// Depends on mrac_pkg and mrac_cell.
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------
//  input   | in_valid / in_ready / in_data  | command, position, value
//  result  | out_valid / out_ready/out_data | index, index_valid, advance_status
//  config  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// A result is loaded after the sequencer passes LAUNCH, SWEEP and DONE (DONE
// straight from IDLE when no digit is in use), and the next input is taken
// only back in IDLE, so one item is swept at a time: a token walks the cell row
// one digit per cycle from the last in-use digit, and the one shared multiply-
// accumulate consumes one digit per cycle behind it. Reset is synchronous and
// clears all digits, known bits and config at once. A result waits in the
// output register; the next item is taken while it waits, and a finished sweep
// holds until the output register is free.
`default_nettype none
module mixed_radix_assignment_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mrac_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mrac_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrac_pkg::RADICES_W-1:0]      cfg_data
);

  localparam int MD = mrac_pkg::MAX_DIGITS;
  localparam int DW = mrac_pkg::DIGIT_WIDTH;
  localparam int RW = mrac_pkg::RADIX_WIDTH;
  localparam int IW = mrac_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_SWEEP, S_DONE} state_t;

  state_t                           state_r;
  logic [mrac_pkg::RADICES_W-1:0]   radices_r;
  logic [mrac_pkg::NUM_W-1:0]       num_digits_r;
  logic [mrac_pkg::NUM_W-1:0]       n_used;
  logic                             in_xfer, launch, adv_r;
  logic [IW-1:0]                    idx_r, stride_r;
  logic                             valid_r;
  logic [mrac_pkg::STAT_W-1:0]      status_r;
  logic                             out_valid_r;
  mrac_pkg::out_item_t              out_data_r;

  logic [MD-1:0]                    tok_in, carry_in, tok_out, carry_out;
  mrac_pkg::cell_wr_t               cell_wr [MD];
  mrac_pkg::cell_tap_t              taps    [MD];
  mrac_pkg::cell_tap_t              tap_any;
  logic [IW+DW-1:0]                 mac_prod;
  logic [IW+RW-1:0]                 stride_prod;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign launch    = (state_r == S_LAUNCH);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp digits in use to the row length
  assign n_used = (num_digits_r > mrac_pkg::NUM_W'(MD)) ? mrac_pkg::NUM_W'(MD) : num_digits_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radices_r    <= '0;
      num_digits_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrac_pkg::CFG_RADICES:    radices_r    <= cfg_data;
        mrac_pkg::CFG_NUM_DIGITS: num_digits_r <= cfg_data[mrac_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell row: token and carry enter at the last in-use digit, move toward digit 0
  for (genvar d = 0; d < MD; d++) begin : g_cell
    logic inject;
    assign inject = launch && (n_used == mrac_pkg::NUM_W'(d + 1));
    if (d == MD - 1) begin : g_end
      assign tok_in[d]   = inject;
      assign carry_in[d] = inject & adv_r;
    end else begin : g_mid
      assign tok_in[d]   = inject | tok_out[d+1];
      assign carry_in[d] = (inject & adv_r) | carry_out[d+1];
    end

    assign cell_wr[d].wr = in_xfer &&
        ((in_data.command == mrac_pkg::CMD_SET_ONE &&
          in_data.position == mrac_pkg::POS_W'(d)) ||
         (in_data.command == mrac_pkg::CMD_SET_ALL &&
          mrac_pkg::NUM_W'(d) < n_used));
    assign cell_wr[d].clr   = in_xfer && (in_data.command == mrac_pkg::CMD_UNSET_ALL);
    assign cell_wr[d].wdata = in_data.value[DW-1:0];

    mrac_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr          (cell_wr[d]),
      .radix       (radices_r[RW*d +: RW]),
      .tok_in      (tok_in[d]),
      .carry_in    (carry_in[d]),
      .tok_out_r   (tok_out[d]),
      .carry_out_r (carry_out[d]),
      .tap_r       (taps[d])
    );
  end

  // Gather the one active tap; idle cells still show their stored digit
  always_comb begin
    tap_any = '0;
    for (int d = 0; d < MD; d++) begin
      if (taps[d].vld) begin
        tap_any = tap_any | taps[d];
      end
    end
  end

  assign mac_prod    = stride_r * tap_any.value;
  assign stride_prod = stride_r * tap_any.radix;

  // Sequencer, index accumulate and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      adv_r       <= 1'b0;
      status_r    <= mrac_pkg::STAT_NONE;
    end else begin
      // Drop the result once transferred, unless a new one loads now
      if (out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            adv_r    <= (in_data.command == mrac_pkg::CMD_ADVANCE);
            idx_r    <= '0;
            stride_r <= IW'(1);
            valid_r  <= 1'b1;
            if (n_used == '0) begin
              status_r <= (in_data.command == mrac_pkg::CMD_ADVANCE) ?
                          mrac_pkg::STAT_WRAPPED : mrac_pkg::STAT_NONE;
              state_r  <= S_DONE;
            end else begin
              status_r <= mrac_pkg::STAT_NONE;
              state_r  <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          state_r <= S_SWEEP;
        end
        S_SWEEP: begin
          if (tap_any.vld) begin
            idx_r    <= idx_r + mac_prod[IW-1:0];
            stride_r <= stride_prod[IW-1:0];
            valid_r  <= valid_r & tap_any.known;
            if (tap_any.stop) begin
              status_r <= mrac_pkg::STAT_STOPPED;
            end else if (tap_any.adv) begin
              status_r <= mrac_pkg::STAT_ADVANCED;
            end
          end
          if (taps[0].vld) begin
            if (carry_out[0]) begin
              status_r <= mrac_pkg::STAT_WRAPPED;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                   <= 1'b1;
            out_data_r.index              <= valid_r ? idx_r : '0;
            out_data_r.index_valid        <= valid_r;
            out_data_r.advance_status     <= status_r;
            state_r                       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // At most one cell holds the sweep token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_in))
    else $error("sweep token in more than one cell");

  // No sweep activity while waiting for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tok_in == '0 && tok_out == '0))
    else $error("sweep token moving while idle");

  // An invalid assignment reports a zero index
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.index_valid) |-> (out_data_r.index == '0))
    else $error("nonzero index on invalid assignment");

  // Stopping at an unset digit leaves the assignment invalid
  a_stop_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.advance_status == mrac_pkg::STAT_STOPPED)
      |-> !out_data_r.index_valid)
    else $error("stopped advance reported a valid index");

endmodule
`default_nettype wire

// ===== hw/rtl/mrac_cell.sv =====
// One digit cell: holds a digit value and its known bit, applies the carry of
// an advance when the sweep token passes, and hands token and carry onward.
// Depends on mrac_pkg.
`default_nettype none
module mrac_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrac_pkg::cell_wr_t                  wr,
  input  logic [mrac_pkg::RADIX_WIDTH-1:0]    radix,
  input  logic                                tok_in,
  input  logic                                carry_in,
  output logic                                tok_out_r,
  output logic                                carry_out_r,
  output mrac_pkg::cell_tap_t                 tap_r
);

  logic [mrac_pkg::DIGIT_WIDTH-1:0] value_r, value_nxt;
  logic                             known_r, known_nxt;
  logic [mrac_pkg::CMP_WIDTH-1:0]   inc;
  logic                             ovf, stop, adv, carry_nxt;

  // Increment and overflow check against this digit's radix
  always_comb begin
    inc       = mrac_pkg::CMP_WIDTH'(value_r) + mrac_pkg::CMP_WIDTH'(1);
    ovf       = !(inc < mrac_pkg::CMP_WIDTH'(radix));
    stop      = tok_in & carry_in & ~known_r;
    adv       = tok_in & carry_in & known_r & ~ovf;
    carry_nxt = tok_in & carry_in & known_r & ovf;
  end

  // Next digit: command writes, else the carry result
  always_comb begin
    value_nxt = value_r;
    known_nxt = known_r;
    if (carry_nxt) begin
      value_nxt = '0;
    end else if (adv) begin
      value_nxt = inc[mrac_pkg::DIGIT_WIDTH-1:0];
    end
    if (wr.wr) begin
      value_nxt = wr.wdata;
      known_nxt = 1'b1;
    end
    if (wr.clr) begin
      known_nxt = 1'b0;
    end
  end

  // Hold the digit, pass token and carry to the next more significant cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r     <= '0;
      known_r     <= 1'b0;
      tok_out_r   <= 1'b0;
      carry_out_r <= 1'b0;
      tap_r       <= '0;
    end else begin
      value_r     <= value_nxt;
      known_r     <= known_nxt;
      tok_out_r   <= tok_in;
      carry_out_r <= carry_nxt;
      tap_r.vld   <= tok_in;
      tap_r.value <= value_nxt;
      tap_r.known <= known_nxt;
      tap_r.radix <= radix;
      tap_r.stop  <= stop;
      tap_r.adv   <= adv;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_mixed_radix_assignment_counter.sv =====
// Testbench for the mixed-radix assignment counter: directed and random commands
// checked against an in-bench digit model through valid/ready channels.
// Depends on mrac_pkg and the mixed_radix_assignment_counter RTL.
module tb_mixed_radix_assignment_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  mrac_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  mrac_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [mrac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mrac_pkg::RADICES_W-1:0] cfg_data;

  // Digit model and its configuration copy
  logic [mrac_pkg::DIGIT_WIDTH-1:0] digit_val [mrac_pkg::MAX_DIGITS];
  bit digit_set [mrac_pkg::MAX_DIGITS];
  logic [mrac_pkg::RADICES_W-1:0] radices_cfg;
  logic [mrac_pkg::NUM_W-1:0] digits_cfg;

  mrac_pkg::out_item_t pending_reports [$];
  mrac_pkg::out_item_t want_report;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold = 0;

  mixed_radix_assignment_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one command to the digit model and return the report it produces
  function automatic mrac_pkg::out_item_t predict_assignment(input mrac_pkg::in_item_t item);
    int n;
    int k;
    bit done;
    bit all_known;
    logic [mrac_pkg::DIGIT_WIDTH:0] bumped;
    logic [mrac_pkg::RADIX_WIDTH-1:0] radix;
    logic [mrac_pkg::IDX_W-1:0] idx;
    logic [mrac_pkg::IDX_W-1:0] stride;
    mrac_pkg::status_t st;
    mrac_pkg::out_item_t rep;
    n = (digits_cfg > mrac_pkg::MAX_DIGITS) ? mrac_pkg::MAX_DIGITS : int'(digits_cfg);
    st = mrac_pkg::STAT_NONE;
    case (item.command)
      mrac_pkg::CMD_SET_ONE: begin
        digit_val[item.position] = item.value;
        digit_set[item.position] = 1'b1;
      end
      mrac_pkg::CMD_SET_ALL: begin
        for (k = 0; k < n; k++) begin
          digit_val[k] = item.value;
          digit_set[k] = 1'b1;
        end
      end
      mrac_pkg::CMD_UNSET_ALL: begin
        for (k = 0; k < mrac_pkg::MAX_DIGITS; k++) digit_set[k] = 1'b0;
      end
      default: begin
        // odometer step from the last in-use digit
        st = mrac_pkg::STAT_WRAPPED;
        done = 1'b0;
        for (k = n - 1; k >= 0 && !done; k--) begin
          if (!digit_set[k]) begin
            st = mrac_pkg::STAT_STOPPED;
            done = 1'b1;
          end else begin
            radix = radices_cfg[8*k +: 8];
            bumped = {1'b0, digit_val[k]} + 1'b1;
            if (bumped < {1'b0, radix}) begin
              digit_val[k] = bumped[mrac_pkg::DIGIT_WIDTH-1:0];
              st = mrac_pkg::STAT_ADVANCED;
              done = 1'b1;
            end else begin
              digit_val[k] = '0;
            end
          end
        end
      end
    endcase
    // row-major index, last digit has stride one
    idx = '0;
    stride = 64'd1;
    all_known = 1'b1;
    for (k = n - 1; k >= 0; k--) begin
      if (!digit_set[k]) all_known = 1'b0;
      idx = idx + stride * digit_val[k];
      stride = stride * radices_cfg[8*k +: 8];
    end
    rep.index = all_known ? idx : '0;
    rep.index_valid = all_known;
    rep.advance_status = st;
    return rep;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic mrac_pkg::in_item_t make_item(input mrac_pkg::cmd_t c,
                                                   input int unsigned pos,
                                                   input int unsigned val);
    mrac_pkg::in_item_t item;
    item.command = c;
    item.position = pos[mrac_pkg::POS_W-1:0];
    item.value = val[mrac_pkg::VAL_W-1:0];
    return item;
  endfunction

  function automatic int unsigned small_value();
    return ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4);
  endfunction

  // Offer one command, hold it until transfer, then update the model
  task automatic issue_command(input mrac_pkg::in_item_t item);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports = {pending_reports, predict_assignment(item)};
  endtask

  task automatic write_config(input mrac_pkg::cfg_reg_t which,
                              input logic [mrac_pkg::RADICES_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (which == mrac_pkg::CFG_RADICES) radices_cfg = data;
    else digits_cfg = data[mrac_pkg::NUM_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every report is back and the sweep has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic randomize_config();
    logic [mrac_pkg::RADICES_W-1:0] rad;
    logic [mrac_pkg::RADICES_W-1:0] nd_word;
    int d;
    if ($urandom_range(7) == 0) begin
      rad = {$urandom, $urandom};
    end else begin
      for (d = 0; d < mrac_pkg::MAX_DIGITS; d++) begin
        case ($urandom_range(11))
          0: rad[8*d +: 8] = 8'd0;
          1: rad[8*d +: 8] = 8'd1;
          2: rad[8*d +: 8] = 8'd255;
          3: rad[8*d +: 8] = 8'($urandom_range(255));
          default: rad[8*d +: 8] = 8'($urandom_range(5, 2));
        endcase
      end
    end
    nd_word = {$urandom, $urandom};
    nd_word[mrac_pkg::NUM_W-1:0] = ($urandom_range(9) == 0) ?
        mrac_pkg::NUM_W'($urandom_range(15, 9)) : mrac_pkg::NUM_W'($urandom_range(8));
    if ($urandom_range(1)) begin
      write_config(mrac_pkg::CFG_RADICES, rad);
      write_config(mrac_pkg::CFG_NUM_DIGITS, nd_word);
    end else begin
      write_config(mrac_pkg::CFG_NUM_DIGITS, nd_word);
      write_config(mrac_pkg::CFG_RADICES, rad);
    end
  endtask

  function automatic mrac_pkg::in_item_t random_item();
    logic [$bits(mrac_pkg::in_item_t)-1:0] raw;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60)
      return make_item(mrac_pkg::CMD_ADVANCE, $urandom_range(7), $urandom_range(255));
    if (pick < 75)
      return make_item(mrac_pkg::CMD_SET_ONE, $urandom_range(7), small_value());
    if (pick < 85)
      return make_item(mrac_pkg::CMD_SET_ALL, $urandom_range(7), small_value());
    if (pick < 90)
      return make_item(mrac_pkg::CMD_UNSET_ALL, $urandom_range(7), $urandom_range(255));
    raw = $bits(mrac_pkg::in_item_t)'($urandom);
    return raw;
  endfunction

  // Reset configuration: no digits in use
  task automatic test_empty_assignment();
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 7, 255));
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 9));
    issue_command(make_item(mrac_pkg::CMD_UNSET_ALL, 0, 0));
    wait_idle();
  endtask

  // Radices 0, 1 and 255 with a digit count above the maximum
  task automatic test_edge_radices();
    write_config(mrac_pkg::CFG_RADICES, 64'h00_01_FF_03_04_05_06_07);
    write_config(mrac_pkg::CFG_NUM_DIGITS, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 255));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 5, 253));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 2, 5));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_UNSET_ALL, 7, 255));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 7, 0));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 0, 6));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    wait_idle();
  endtask

  // Digits stored beyond the in-use count, then zero radices
  task automatic test_unused_positions();
    write_config(mrac_pkg::CFG_RADICES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_config(mrac_pkg::CFG_NUM_DIGITS, 64'd2);
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 1));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 6, 9));
    issue_command(make_item(mrac_pkg::CMD_SET_ONE, 0, 254));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    wait_idle();
    write_config(mrac_pkg::CFG_NUM_DIGITS, 64'd8);
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 254));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    wait_idle();
    write_config(mrac_pkg::CFG_RADICES, 64'd0);
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 5));
    issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    wait_idle();
  endtask

  // Hold the result side off while commands keep coming
  task automatic test_result_backpressure();
    int j;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    randomize_config();
    issue_command(make_item(mrac_pkg::CMD_SET_ALL, 0, 0));
    @(posedge clk);
    rx_hold = 400;
    for (j = 0; j < 40; j++) issue_command(make_item(mrac_pkg::CMD_ADVANCE, 0, 0));
    wait_idle();
  endtask

  // Bursts that open with a full assignment and then mostly advance
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned j;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      randomize_config();
      burst = $urandom_range(80, 20);
      issue_command(make_item(mrac_pkg::CMD_SET_ALL, $urandom_range(7), small_value()));
      sent++;
      for (j = 1; j < burst && sent < n_items; j++) begin
        issue_command(random_item());
        sent++;
      end
    end
    wait_idle();
  endtask

  // Result side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("result with none expected: index=%h valid=%b status=%0d",
                               out_data.index, out_data.index_valid,
                               out_data.advance_status));
      end else begin
        want_report = pending_reports.pop_front();
        if (out_data.index !== want_report.index ||
            out_data.index_valid !== want_report.index_valid ||
            out_data.advance_status !== want_report.advance_status) begin
          note_failure($sformatf(
            "index exp %h got %h, valid exp %b got %b, status exp %0d got %0d",
            want_report.index, out_data.index, want_report.index_valid,
            out_data.index_valid, want_report.advance_status, out_data.advance_status));
        end
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mixed_radix_assignment_counter verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    radices_cfg = '0;
    digits_cfg = '0;
    for (int d = 0; d < mrac_pkg::MAX_DIGITS; d++) begin
      digit_val[d] = '0;
      digit_set[d] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 11;
    rx_idle_pct = 11;
    test_empty_assignment();
    test_edge_radices();
    test_unused_positions();
    test_random_traffic(700, 11, 80);
    test_result_backpressure();
    test_random_traffic(700, 80, 11);
    test_random_traffic(600, 0, 0);

    wait_idle();
    if (pending_reports.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_reports.size()));
    if (mismatch_count == 0) begin
      $display("mixed_radix_assignment_counter verification clean");
    end else begin
      $display("mixed_radix_assignment_counter verification failed");
    end
    $finish;
  end

endmodule
